@@ rtl/light_radiance_evaluator_top_assert.svh @@
// Assertion macros for the light radiance evaluator.
// Needs clk and arst_n in the scope of each use.
`ifndef LIGHT_RADIANCE_EVALUATOR_TOP_ASSERT_SVH
`define LIGHT_RADIANCE_EVALUATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define LRE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("light radiance evaluator: check failed");
`define LRE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("light radiance evaluator: check failed");
`else
`define LRE_ASSERT_IMPL(lbl, ante, cons)
`define LRE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/lre_pkg.sv @@
// Types and fixed widths for the light radiance evaluator.
// No dependencies.
`default_nettype none
package lre_pkg;
	localparam int PT_W  = 21;
	localparam int D_W   = 22;
	localparam int SQ1_W = 43;
	localparam int SQ_W  = 44;
	localparam int R_W   = 22;
	localparam int DP_W  = 38;
	localparam int DOT_W = 40;
	localparam int DEN_W = 61;
	localparam int CQ_W  = 15;
	localparam int FM_W  = 16;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	typedef enum logic [1:0] {
		KIND_DIR   = 2'd0,
		KIND_POINT = 2'd1,
		KIND_SPOT  = 2'd2
	} light_kind_t;

	typedef enum logic [2:0] {
		REG_KIND = 3'd0,
		REG_POS  = 3'd1,
		REG_DIR  = 3'd2,
		REG_COEF = 3'd3,
		REG_INT  = 3'd4,
		REG_CIN  = 3'd5,
		REG_COUT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic neg;
		logic rz;
		logic ovf;
	} cos_flags_t;

	typedef struct packed {
		logic ddz;
		logic hard;
		logic neg;
		logic ovf;
	} fall_flags_t;
endpackage
`default_nettype wire

@@ rtl/light_radiance_evaluator_top.sv @@
// Light radiance evaluator: point, spot and directional light on a stream of points.
// Depends on lre_pkg and light_radiance_evaluator_top_assert.svh.
//
// channel   | dir | handshake        | payload
// s_*       | in  | tvalid/tready    | tdata: point_x, point_y, point_z
// m_*       | out | tvalid/tready    | tdata: radiance r, g, b, saturated
// p*        | in  | psel/penable     | 64-bit registers at 8*index
//
// One point per cycle while the output is not stalled. The colour dividers
// retire one quotient bit per stage.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A full last stage with the output held stalls every stage; an empty one lets them advance.
`default_nettype none
`include "light_radiance_evaluator_top_assert.svh"
module light_radiance_evaluator_top #(
	parameter int COORD_FRAC_BITS = 10,
	parameter int COLOR_BITS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // point_x[20:0], point_y[41:21], point_z[62:42], pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // red[15:0], green[31:16], blue[47:32], saturated[48], pad
);
	import lre_pkg::*;

	localparam int F      = COORD_FRAC_BITS;
	localparam int NUM_SH = 8 + 2 * F;
	localparam int NUM_W  = 16 + NUM_SH;
	localparam int VC_W   = COLOR_BITS + 14;
	localparam int PROD_W = VC_W + 15;
	localparam int SV     = 27 + NUM_W;
	localparam int LAST   = SV + 2;
	localparam int FD     = SV - 59;
	localparam logic [63:0] CMAX = (64'd1 << COLOR_BITS) - 64'd1;

	// configuration
	logic [1:0]         kind_q;
	logic [62:0]        pos_q;
	logic [47:0]        dir_q;
	logic [47:0]        coef_q;
	logic [47:0]        int_q;
	logic signed [15:0] ci_q;
	logic signed [15:0] co_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_POINT;
			pos_q  <= '0;
			dir_q  <= '0;
			coef_q <= 48'd256;
			int_q  <= '0;
			ci_q   <= 16'sd16384;
			co_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[5:3]))
				REG_KIND: kind_q <= pwdata[1:0];
				REG_POS:  pos_q  <= pwdata[62:0];
				REG_DIR:  dir_q  <= pwdata[47:0];
				REG_COEF: coef_q <= pwdata[47:0];
				REG_INT:  int_q  <= pwdata[47:0];
				REG_CIN:  ci_q   <= pwdata[15:0];
				REG_COUT: co_q   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[5:3]))
			REG_KIND: prdata = 64'(kind_q);
			REG_POS:  prdata = 64'(pos_q);
			REG_DIR:  prdata = 64'(dir_q);
			REG_COEF: prdata = 64'(coef_q);
			REG_INT:  prdata = 64'(int_q);
			REG_CIN:  prdata = 64'(unsigned'(ci_q));
			REG_COUT: prdata = 64'(unsigned'(co_q));
			default:  prdata = '0;
		endcase
	end

	// flow control
	logic             vld_s [1:LAST-1];
	logic             en;
	logic             out_ld;

	assign out_ld   = !m_tvalid || m_tready;
	assign en       = out_ld || !vld_s[LAST-1];
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i < LAST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int i = 2; i < LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_ld) m_tvalid <= vld_s[LAST-1];
	end

	// stages 1..3: offset, squares and dot terms, sums
	logic signed [D_W-1:0]   d_s1  [3];
	logic [SQ1_W-1:0]        sq_s2 [3];
	logic signed [DP_W-1:0]  dp_s2 [3];
	logic [SQ_W-1:0]         s_s3;
	logic signed [DOT_W-1:0] dot_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= D_W'($signed(s_tdata[PT_W*i +: PT_W]))
					- D_W'($signed(pos_q[PT_W*i +: PT_W]));
				sq_s2[i] <= SQ1_W'(d_s1[i] * d_s1[i]);
				dp_s2[i] <= DP_W'(d_s1[i] * $signed(dir_q[16*i +: 16]));
			end
			s_s3 <= SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);
			dot_s3 <= DOT_W'(dp_s2[0]) + DOT_W'(dp_s2[1]) + DOT_W'(dp_s2[2]);
		end
	end

	// stages 4..25: square root, one root bit per stage
	logic [R_W+1:0]          rt_rem_s  [R_W];
	logic [R_W-1:0]          rt_root_s [R_W];
	logic [SQ_W-1:0]         rt_s_s    [R_W];
	logic signed [DOT_W-1:0] rt_dot_s  [R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_sqrt
		logic [R_W+1:0]          rem_i;
		logic [R_W-1:0]          root_i;
		logic [SQ_W-1:0]         s_i;
		logic signed [DOT_W-1:0] dot_i;
		logic [R_W+3:0]          t;
		logic [R_W+3:0]          tst;
		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign s_i    = s_s3;
			assign dot_i  = dot_s3;
		end else begin : g_next
			assign rem_i  = rt_rem_s[k-1];
			assign root_i = rt_root_s[k-1];
			assign s_i    = rt_s_s[k-1];
			assign dot_i  = rt_dot_s[k-1];
		end
		assign t   = {rem_i, s_i[2*(R_W-1-k) +: 2]};
		assign tst = (R_W+4)'({root_i, 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= tst) begin
					rt_rem_s[k]  <= (R_W+2)'(t - tst);
					rt_root_s[k] <= {root_i[R_W-2:0], 1'b1};
				end else begin
					rt_rem_s[k]  <= (R_W+2)'(t);
					rt_root_s[k] <= {root_i[R_W-2:0], 1'b0};
				end
				rt_s_s[k]   <= s_i;
				rt_dot_s[k] <= dot_i;
			end
		end
	end

	logic [R_W-1:0]          r_v;
	logic [SQ_W-1:0]         s_v;
	logic signed [DOT_W-1:0] dot_v;
	assign r_v   = rt_root_s[R_W-1];
	assign s_v   = rt_s_s[R_W-1];
	assign dot_v = rt_dot_s[R_W-1];

	// stages 26..27: attenuation denominator
	logic [37:0]      lr_s26;
	logic [37:0]      qsl_s26;
	logic [37:0]      qsh_s26;
	logic [DEN_W-1:0] den_s27;
	logic             den_z;

	assign den_z = (coef_q[15:0] == '0) && (lr_s26 == '0) && (qsl_s26 == '0)
		&& (qsh_s26 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			lr_s26  <= 38'(coef_q[31:16] * r_v);
			qsl_s26 <= 38'(coef_q[47:32] * s_v[21:0]);
			qsh_s26 <= 38'(coef_q[47:32] * s_v[43:22]);
			den_s27 <= ((DEN_W'(coef_q[15:0]) << (2 * F)) + (DEN_W'(lr_s26) << F)
				+ DEN_W'(qsl_s26) + (DEN_W'(qsh_s26) << 22)) | DEN_W'(den_z);
		end
	end

	// stages 28..SV: colour dividers, one quotient bit per stage
	logic [NUM_W-1:0] num_c [3];
	logic [DEN_W-1:0] dv_den_s [NUM_W];
	logic [DEN_W-1:0] dv_rem_s [3][NUM_W];
	logic [NUM_W-1:0] dv_q_s   [3][NUM_W];

	always_comb begin
		for (int i = 0; i < 3; i++) num_c[i] = {int_q[16*i +: 16], {NUM_SH{1'b0}}};
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic [DEN_W-1:0] den_i;
		if (k == 0) begin : g_first
			assign den_i = den_s27;
		end else begin : g_next
			assign den_i = dv_den_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) dv_den_s[k] <= den_i;
		end
		for (genvar c = 0; c < 3; c++) begin : g_ch
			logic [DEN_W-1:0] rem_i;
			logic [NUM_W-1:0] q_i;
			logic [DEN_W:0]   t;
			if (k == 0) begin : g_first
				assign rem_i = '0;
				assign q_i   = '0;
			end else begin : g_next
				assign rem_i = dv_rem_s[c][k-1];
				assign q_i   = dv_q_s[c][k-1];
			end
			assign t = {rem_i, num_c[c][NUM_W-1-k]};
			always_ff @(posedge clk) begin
				if (en) begin
					if (t >= {1'b0, den_i}) begin
						dv_rem_s[c][k] <= DEN_W'(t - {1'b0, den_i});
						dv_q_s[c][k]   <= {q_i[NUM_W-2:0], 1'b1};
					end else begin
						dv_rem_s[c][k] <= DEN_W'(t);
						dv_q_s[c][k]   <= {q_i[NUM_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// stage 26: cosine divider setup
	logic [DOT_W-1:0] dot_abs;
	logic [R_W-1:0]   cd_rem0_s26;
	logic [CQ_W-1:0]  cd_alo_s26;
	logic [R_W-1:0]   cd_r_s26;
	cos_flags_t       cd_fl_s26;

	assign dot_abs = dot_v[DOT_W-1] ? DOT_W'(-dot_v) : DOT_W'(dot_v);

	always_ff @(posedge clk) begin
		if (en) begin
			cd_rem0_s26   <= R_W'(dot_abs >> CQ_W);
			cd_alo_s26    <= dot_abs[CQ_W-1:0];
			cd_r_s26      <= r_v;
			cd_fl_s26.neg <= dot_v[DOT_W-1];
			cd_fl_s26.rz  <= (r_v == '0);
			cd_fl_s26.ovf <= (dot_abs >> CQ_W) >= DOT_W'(r_v);
		end
	end

	// stages 27..41: cosine divider
	logic [R_W-1:0]  cd_rem_s [CQ_W];
	logic [CQ_W-1:0] cd_q_s   [CQ_W];
	logic [R_W-1:0]  cd_r_s   [CQ_W];
	logic [CQ_W-1:0] cd_alo_s [CQ_W];
	cos_flags_t      cd_fl_s  [CQ_W];

	for (genvar k = 0; k < CQ_W; k++) begin : g_cdiv
		logic [R_W-1:0]  rem_i;
		logic [CQ_W-1:0] q_i;
		logic [R_W-1:0]  r_i;
		logic [CQ_W-1:0] alo_i;
		cos_flags_t      fl_i;
		logic [R_W:0]    t;
		if (k == 0) begin : g_first
			assign rem_i = cd_rem0_s26;
			assign q_i   = '0;
			assign r_i   = cd_r_s26;
			assign alo_i = cd_alo_s26;
			assign fl_i  = cd_fl_s26;
		end else begin : g_next
			assign rem_i = cd_rem_s[k-1];
			assign q_i   = cd_q_s[k-1];
			assign r_i   = cd_r_s[k-1];
			assign alo_i = cd_alo_s[k-1];
			assign fl_i  = cd_fl_s[k-1];
		end
		assign t = {rem_i, alo_i[CQ_W-1-k]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, r_i}) begin
					cd_rem_s[k] <= R_W'(t - {1'b0, r_i});
					cd_q_s[k]   <= {q_i[CQ_W-2:0], 1'b1};
				end else begin
					cd_rem_s[k] <= R_W'(t);
					cd_q_s[k]   <= {q_i[CQ_W-2:0], 1'b0};
				end
				cd_r_s[k]   <= r_i;
				cd_alo_s[k] <= alo_i;
				cd_fl_s[k]  <= fl_i;
			end
		end
	end

	// stage 42: clamped cosine, falloff numerator and span
	logic [14:0]        cs_mag;
	logic signed [15:0] cs;
	logic signed [16:0] num_s42;
	logic signed [16:0] dd_s42;
	cos_flags_t         cfl;

	assign cfl = cd_fl_s[CQ_W-1];

	always_comb begin
		if (cfl.rz) cs_mag = '0;
		else if (cfl.ovf || cd_q_s[CQ_W-1] > ONE_Q14) cs_mag = ONE_Q14;
		else cs_mag = cd_q_s[CQ_W-1];
		cs = cfl.neg ? -$signed(16'(cs_mag)) : $signed(16'(cs_mag));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s42 <= 17'(cs) - 17'(co_q);
			dd_s42  <= 17'(ci_q) - 17'(co_q);
		end
	end

	// stage 43: falloff divider setup
	logic [16:0]      num_abs;
	logic [16:0]      dd_abs;
	logic [FM_W-1:0]  fo_rem0_s43;
	logic [FM_W-1:0]  fo_b_s43;
	logic [CQ_W-1:0]  fo_alo_s43;
	fall_flags_t      fo_fl_s43;

	assign num_abs = num_s42[16] ? 17'(-num_s42) : 17'(num_s42);
	assign dd_abs  = dd_s42[16] ? 17'(-dd_s42) : 17'(dd_s42);

	always_ff @(posedge clk) begin
		if (en) begin
			fo_rem0_s43    <= FM_W'(num_abs[FM_W-1:1]);
			fo_b_s43       <= dd_abs[FM_W-1:0];
			fo_alo_s43     <= {num_abs[0], {(CQ_W-1){1'b0}}};
			fo_fl_s43.ddz  <= (dd_s42 == '0);
			fo_fl_s43.hard <= !num_s42[16];
			fo_fl_s43.neg  <= (num_s42 != '0) && (num_s42[16] != dd_s42[16]);
			fo_fl_s43.ovf  <= FM_W'(num_abs[FM_W-1:1]) >= dd_abs[FM_W-1:0];
		end
	end

	// stages 44..58: falloff divider
	logic [FM_W-1:0] fo_rem_s [CQ_W];
	logic [CQ_W-1:0] fo_q_s   [CQ_W];
	logic [FM_W-1:0] fo_b_s   [CQ_W];
	logic [CQ_W-1:0] fo_alo_s [CQ_W];
	fall_flags_t     fo_fl_s  [CQ_W];

	for (genvar k = 0; k < CQ_W; k++) begin : g_fdiv
		logic [FM_W-1:0] rem_i;
		logic [CQ_W-1:0] q_i;
		logic [FM_W-1:0] b_i;
		logic [CQ_W-1:0] alo_i;
		fall_flags_t     fl_i;
		logic [FM_W:0]   t;
		if (k == 0) begin : g_first
			assign rem_i = fo_rem0_s43;
			assign q_i   = '0;
			assign b_i   = fo_b_s43;
			assign alo_i = fo_alo_s43;
			assign fl_i  = fo_fl_s43;
		end else begin : g_next
			assign rem_i = fo_rem_s[k-1];
			assign q_i   = fo_q_s[k-1];
			assign b_i   = fo_b_s[k-1];
			assign alo_i = fo_alo_s[k-1];
			assign fl_i  = fo_fl_s[k-1];
		end
		assign t = {rem_i, alo_i[CQ_W-1-k]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, b_i}) begin
					fo_rem_s[k] <= FM_W'(t - {1'b0, b_i});
					fo_q_s[k]   <= {q_i[CQ_W-2:0], 1'b1};
				end else begin
					fo_rem_s[k] <= FM_W'(t);
					fo_q_s[k]   <= {q_i[CQ_W-2:0], 1'b0};
				end
				fo_b_s[k]   <= b_i;
				fo_alo_s[k] <= alo_i;
				fo_fl_s[k]  <= fl_i;
			end
		end
	end

	// stage 59 onward: falloff factor, delayed to meet the colour quotients
	logic [14:0]  f_val;
	logic [14:0]  fd_s [0:FD];
	fall_flags_t  ffl;

	assign ffl = fo_fl_s[CQ_W-1];

	always_comb begin
		if (ffl.ddz) f_val = ffl.hard ? ONE_Q14 : '0;
		else if (ffl.neg) f_val = '0;
		else if (ffl.ovf || fo_q_s[CQ_W-1] > ONE_Q14) f_val = ONE_Q14;
		else f_val = fo_q_s[CQ_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fd_s[0] <= f_val;
			for (int j = 1; j <= FD; j++) fd_s[j] <= fd_s[j-1];
		end
	end

	// stage SV+1: point clamp and spot product
	logic [COLOR_BITS-1:0] pval_sm [3];
	logic                  psat_sm [3];
	logic                  big_sm  [3];
	logic [PROD_W-1:0]     prod_sm [3];
	logic                  fz_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pval_sm[i] <= COLOR_BITS'(dv_q_s[i][NUM_W-1]);
				psat_sm[i] <= 64'(dv_q_s[i][NUM_W-1]) > CMAX;
				big_sm[i]  <= (64'(dv_q_s[i][NUM_W-1]) >> VC_W) != '0;
				prod_sm[i] <= PROD_W'(VC_W'(dv_q_s[i][NUM_W-1])) * PROD_W'(fd_s[FD]);
			end
			fz_sm <= (fd_s[FD] == '0);
		end
	end

	// output stage: mode select and saturation
	logic [63:0] chan   [3];
	logic        csat   [3];
	logic [63:0] spot_v [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			spot_v[i] = 64'(prod_sm[i] >> 14);
			case (kind_q)
				KIND_DIR: begin
					csat[i] = 64'(int_q[16*i +: 16]) > CMAX;
					chan[i] = csat[i] ? CMAX : 64'(int_q[16*i +: 16]);
				end
				KIND_SPOT: begin
					if (fz_sm) begin
						csat[i] = 1'b0;
						chan[i] = '0;
					end else begin
						csat[i] = big_sm[i] || (spot_v[i] > CMAX);
						chan[i] = csat[i] ? CMAX : spot_v[i];
					end
				end
				default: begin
					csat[i] = psat_sm[i];
					chan[i] = psat_sm[i] ? CMAX : 64'(pval_sm[i]);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_tdata <= {7'd0, csat[0] | csat[1] | csat[2],
				chan[2][15:0], chan[1][15:0], chan[0][15:0]};
		end
	end

	`LRE_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_s[1])
	`LRE_ASSERT_NEXT(a_stall_keeps, m_tvalid && !m_tready && vld_s[LAST-1], vld_s[LAST-1])
	`LRE_ASSERT_NEXT(a_bubble_out, m_tready && !vld_s[LAST-1], !m_tvalid)
endmodule
`default_nettype wire
